[design/nnd_pkg.sv]
package nnd_pkg;

	// widths fixed by the register map and the pixel format
	localparam int REG_W   = 13;
	localparam int PIX_W   = 32;
	localparam int COORD_W = 12;
	localparam int IDX_W   = 2;

	// divider operand widths: numerator holds 2*h*tw + w, denominator holds 2*w
	localparam int NUM_W = 2 * REG_W + 2;
	localparam int DEN_W = REG_W + 1;

	// register indexes
	localparam logic [IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
	localparam logic [IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
	localparam logic [IDX_W-1:0] REG_MAX_WIDTH  = 2'd2;

	// frame geometry derived from the registers
	typedef struct packed {
		logic             down;
		logic [REG_W-1:0] w;
		logic [REG_W-1:0] h;
		logic [REG_W-1:0] tw;
		logic [REG_W-1:0] th;
		logic [REG_W-1:0] cq;
		logic [REG_W-1:0] cr;
		logic [REG_W-1:0] rq;
		logic [REG_W-1:0] rr;
	} geom_t;

	// one output item
	typedef struct packed {
		logic               done;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
		logic [PIX_W-1:0]   pixel;
	} result_t;

endpackage

[design/nnd_div.sv]
module nnd_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic [nnd_pkg::NUM_W-1:0] num,
	input  logic [nnd_pkg::DEN_W-1:0] den,
	output logic                     done,
	output logic [nnd_pkg::NUM_W-1:0] quot,
	output logic [nnd_pkg::DEN_W-1:0] rem
);

	localparam int NW    = nnd_pkg::NUM_W;
	localparam int DNW   = nnd_pkg::DEN_W;
	localparam int CNT_W = $clog2(NW);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [NW-1:0]    num_q;
	logic [DNW-1:0]   den_q;
	logic [DNW-1:0]   rem_q;
	logic [DNW:0]     shifted;
	logic [DNW:0]     diff;
	logic             fits;

	// one quotient bit per cycle, restoring form
	assign shifted = {rem_q, num_q[NW-1]};
	assign diff    = shifted - {1'b0, den_q};
	assign fits    = shifted >= {1'b0, den_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CNT_W'(NW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], fits};
			rem_q <= fits ? diff[DNW-1:0] : shifted[DNW-1:0];
		end
	end

	assign done = done_q;
	assign quot = num_q;
	assign rem  = rem_q;

endmodule

[design/nnd_cfg.sv]
module nnd_cfg #(
	parameter int MAX_DIM = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [nnd_pkg::IDX_W-1:0] cfg_index,
	input  logic [nnd_pkg::REG_W-1:0] cfg_data,
	output nnd_pkg::geom_t            geom,
	output logic                      restart,
	output logic                      busy
);

	localparam int RW      = nnd_pkg::REG_W;
	localparam int EFF_MAX = (MAX_DIM < (1 << RW) - 1) ? MAX_DIM : (1 << RW) - 1;
	localparam int RST_TW  = (4096 > EFF_MAX) ? EFF_MAX : 4096;
	localparam logic [RW-1:0] EFF_MAX_V = RW'(EFF_MAX);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_LOAD     = 3'd1;
	localparam logic [2:0] ST_TH_GO    = 3'd2;
	localparam logic [2:0] ST_TH_WAIT  = 3'd3;
	localparam logic [2:0] ST_COL_GO   = 3'd4;
	localparam logic [2:0] ST_COL_WAIT = 3'd5;
	localparam logic [2:0] ST_ROW_GO   = 3'd6;
	localparam logic [2:0] ST_ROW_WAIT = 3'd7;

	logic [2:0]            state_q;
	logic [RW-1:0]         src_width_q;
	logic [RW-1:0]         src_height_q;
	logic [RW-1:0]         max_width_q;
	logic [RW-1:0]         w_eff;
	logic [RW-1:0]         h_eff;
	logic [RW-1:0]         tw_eff;
	logic [2*RW-1:0]       prod_q;
	nnd_pkg::geom_t        geom_q;
	logic                  wr;
	logic                  wr_known;
	logic                  div_start;
	logic                  div_done;
	logic [nnd_pkg::NUM_W-1:0] div_num;
	logic [nnd_pkg::DEN_W-1:0] div_den;
	logic [nnd_pkg::NUM_W-1:0] div_quot;
	logic [nnd_pkg::DEN_W-1:0] div_rem;

	function automatic logic [RW-1:0] clamp_dim(input logic [RW-1:0] v);
		logic [RW-1:0] r;
		r = v;
		if (v == '0)
			r = RW'(1);
		else if (v > EFF_MAX_V)
			r = EFF_MAX_V;
		return r;
	endfunction

	assign cfg_ready = (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign wr        = cfg_valid && cfg_ready;
	assign wr_known  = (cfg_index == nnd_pkg::REG_SRC_WIDTH) ||
		(cfg_index == nnd_pkg::REG_SRC_HEIGHT) || (cfg_index == nnd_pkg::REG_MAX_WIDTH);
	assign restart   = wr && wr_known;

	assign w_eff  = clamp_dim(src_width_q);
	assign h_eff  = clamp_dim(src_height_q);
	assign tw_eff = clamp_dim(max_width_q);

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= RW'(1);
			src_height_q <= RW'(1);
			max_width_q  <= RW'(4096);
		end else if (wr) begin
			case (cfg_index)
				nnd_pkg::REG_SRC_WIDTH:  src_width_q  <= cfg_data;
				nnd_pkg::REG_SRC_HEIGHT: src_height_q <= cfg_data;
				nnd_pkg::REG_MAX_WIDTH:  max_width_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// divider operand select
	always_comb begin
		div_start = 1'b0;
		div_num   = nnd_pkg::NUM_W'(geom_q.w);
		div_den   = nnd_pkg::DEN_W'(geom_q.tw);
		case (state_q)
			ST_TH_GO: begin
				div_start = 1'b1;
				div_num   = nnd_pkg::NUM_W'({prod_q, 1'b0}) + nnd_pkg::NUM_W'(geom_q.w);
				div_den   = {geom_q.w, 1'b0};
			end
			ST_COL_GO: begin
				div_start = 1'b1;
			end
			ST_ROW_GO: begin
				div_start = 1'b1;
				div_num   = nnd_pkg::NUM_W'(geom_q.h);
				div_den   = nnd_pkg::DEN_W'(geom_q.th);
			end
			default: ;
		endcase
	end

	nnd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	// geometry sequencer: when downscaling, target height, then column and row steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			geom_q.down <= 1'b0;
			geom_q.w    <= RW'(1);
			geom_q.h    <= RW'(1);
			geom_q.tw   <= RW'(RST_TW);
			geom_q.th   <= RW'(1);
			geom_q.cq   <= RW'(1);
			geom_q.cr   <= '0;
			geom_q.rq   <= RW'(1);
			geom_q.rr   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (restart)
						state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					geom_q.w    <= w_eff;
					geom_q.h    <= h_eff;
					geom_q.tw   <= tw_eff;
					geom_q.down <= w_eff > tw_eff;
					if (w_eff > tw_eff) begin
						state_q <= ST_TH_GO;
					end else begin
						geom_q.th <= RW'(1);
						geom_q.cq <= RW'(1);
						geom_q.cr <= '0;
						geom_q.rq <= RW'(1);
						geom_q.rr <= '0;
						state_q   <= ST_IDLE;
					end
				end
				ST_TH_GO:  state_q <= ST_TH_WAIT;
				ST_TH_WAIT: begin
					if (div_done) begin
						geom_q.th <= (div_quot == '0) ? RW'(1) : RW'(div_quot);
						state_q   <= ST_COL_GO;
					end
				end
				ST_COL_GO: state_q <= ST_COL_WAIT;
				ST_COL_WAIT: begin
					if (div_done) begin
						geom_q.cq <= RW'(div_quot);
						geom_q.cr <= RW'(div_rem);
						state_q   <= ST_ROW_GO;
					end
				end
				ST_ROW_GO: state_q <= ST_ROW_WAIT;
				ST_ROW_WAIT: begin
					if (div_done) begin
						geom_q.rq <= RW'(div_quot);
						geom_q.rr <= RW'(div_rem);
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// height times target width, registered ahead of the division
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD)
			prod_q <= h_eff * tw_eff;
	end

	assign geom = geom_q;

endmodule

[design/nnd_pos.sv]
module nnd_pos #(
	parameter int MAX_DIM = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      restart,
	input  nnd_pkg::geom_t            geom,
	input  logic                      take,
	input  logic [nnd_pkg::PIX_W-1:0] pixel_in,
	output logic                      kept,
	output nnd_pkg::result_t          res
);

	localparam int RW      = nnd_pkg::REG_W;
	localparam int EFF_MAX = (MAX_DIM < (1 << RW) - 1) ? MAX_DIM : (1 << RW) - 1;
	localparam int DW      = $clog2(EFF_MAX + 1);
	localparam int CW      = $clog2(EFF_MAX);
	localparam int OW      = nnd_pkg::COORD_W;

	logic [CW-1:0] src_col_q;
	logic [CW-1:0] src_row_q;
	logic [DW-1:0] want_col_q;
	logic [DW-1:0] col_rem_q;
	logic [DW-1:0] dst_col_q;
	logic [DW-1:0] want_row_q;
	logic [DW-1:0] row_rem_q;
	logic [DW-1:0] dst_row_q;

	logic [DW-1:0] w, h, tw, th, cq, cr, rq, rr;
	logic [DW-1:0] c, r;
	logic          last_col, last_row, col_hit, row_hit;
	logic [DW:0]   col_sum, row_sum;
	logic          col_wrap, row_wrap;
	logic [DW-1:0] col_rem_nxt, row_rem_nxt;
	logic [DW-1:0] want_col_nxt, want_row_nxt;

	assign w  = DW'(geom.w);
	assign h  = DW'(geom.h);
	assign tw = DW'(geom.tw);
	assign th = DW'(geom.th);
	assign cq = DW'(geom.cq);
	assign cr = DW'(geom.cr);
	assign rq = DW'(geom.rq);
	assign rr = DW'(geom.rr);
	assign c  = DW'(src_col_q);
	assign r  = DW'(src_row_q);

	// position and hit tests
	assign last_col = c >= w - 1'b1;
	assign last_row = r >= h - 1'b1;
	assign col_hit  = c == want_col_q;
	assign row_hit  = r == want_row_q;
	assign kept     = !geom.down || (col_hit && row_hit);

	// next wanted column and row, quotient plus carried remainder
	assign col_sum      = {1'b0, col_rem_q} + {1'b0, cr};
	assign col_wrap     = col_sum >= {1'b0, tw};
	assign col_rem_nxt  = col_wrap ? DW'(col_sum - {1'b0, tw}) : DW'(col_sum);
	assign want_col_nxt = want_col_q + cq + DW'(col_wrap);
	assign row_sum      = {1'b0, row_rem_q} + {1'b0, rr};
	assign row_wrap     = row_sum >= {1'b0, th};
	assign row_rem_nxt  = row_wrap ? DW'(row_sum - {1'b0, th}) : DW'(row_sum);
	assign want_row_nxt = want_row_q + rq + DW'(row_wrap);

	// result fields
	always_comb begin
		res.pixel = pixel_in;
		if (!geom.down) begin
			res.col  = OW'(src_col_q);
			res.row  = OW'(src_row_q);
			res.done = last_col && last_row;
		end else begin
			res.col  = OW'(dst_col_q);
			res.row  = OW'(dst_row_q);
			res.done = (dst_col_q == tw - 1'b1) && (dst_row_q == th - 1'b1);
		end
	end

	// counters and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			want_col_q <= '0;
			col_rem_q  <= '0;
			dst_col_q  <= '0;
			want_row_q <= '0;
			row_rem_q  <= '0;
			dst_row_q  <= '0;
		end else if (restart) begin
			src_col_q  <= '0;
			src_row_q  <= '0;
			want_col_q <= '0;
			col_rem_q  <= '0;
			dst_col_q  <= '0;
			want_row_q <= '0;
			row_rem_q  <= '0;
			dst_row_q  <= '0;
		end else if (take) begin
			if (geom.down) begin
				if (col_hit) begin
					want_col_q <= want_col_nxt;
					col_rem_q  <= col_rem_nxt;
					dst_col_q  <= dst_col_q + 1'b1;
				end
				if (last_col) begin
					want_col_q <= '0;
					col_rem_q  <= '0;
					dst_col_q  <= '0;
					if (row_hit) begin
						want_row_q <= want_row_nxt;
						row_rem_q  <= row_rem_nxt;
						dst_row_q  <= dst_row_q + 1'b1;
					end
				end
			end
			if (last_col) begin
				src_col_q <= '0;
				if (last_row) begin
					src_row_q  <= '0;
					want_row_q <= '0;
					row_rem_q  <= '0;
					dst_row_q  <= '0;
				end else begin
					src_row_q <= src_row_q + 1'b1;
				end
			end else begin
				src_col_q <= src_col_q + 1'b1;
			end
		end
	end

endmodule

[design/nnd_out.sv]
module nnd_out (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  nnd_pkg::result_t push_res,
	output logic             room,
	output logic             out_valid,
	input  logic             out_ready,
	output nnd_pkg::result_t out_res
);

	logic             valid_q;
	logic             skid_valid_q;
	nnd_pkg::result_t main_q;
	nnd_pkg::result_t skid_q;
	logic             pop;
	logic             load_main;

	assign pop       = valid_q && out_ready;
	assign load_main = push && (!valid_q || pop);
	assign room      = !skid_valid_q;

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q      <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (push) begin
			if (load_main)
				valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			if (skid_valid_q)
				skid_valid_q <= 1'b0;
			else
				valid_q <= 1'b0;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (load_main)
			main_q <= push_res;
		else if (push)
			skid_q <= push_res;
		else if (pop && skid_valid_q)
			main_q <= skid_q;
	end

	assign out_valid = valid_q;
	assign out_res   = main_q;

endmodule

[design/nearest_neighbor_downscaler.sv]
// Nearest-neighbor downscaler for an RGBA pixel stream.
// Source pixels enter on the s_ channel in raster order, one per item. When
// the source width exceeds max_width, only the pixels on the nearest-neighbor
// grid come out on the m_ channel, tagged with their output column and row;
// otherwise every pixel passes with its own coordinates. m_tlast marks the
// last pixel of an output frame.
// Registers are written on the cfg_ channel (0 src_width, 1 src_height,
// 2 max_width); the user must write them only while the stream is quiet,
// and the block does not enforce this. A write to one of these registers
// restarts the frame and drops s_tready while the geometry is loaded and,
// when downscaling, the target height and step sizes are worked out by a
// one-bit-per-cycle divider in three 28-bit divisions. Throughput is one
// pixel per clock while s_tready is high; a kept pixel appears on m_tvalid
// in the cycle after it is accepted when the output register is free. A
// pixel that meets a stalled m_tready with the output register full goes
// to a single skid entry, and s_tready stays low while the skid holds it.
// Reset loads src_width 1, src_height 1, max_width 4096 and clears all frame
// position counters.
module nearest_neighbor_downscaler #(
	parameter int MAX_DIM = 4096
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [31:0]               s_tdata,    // pixel_in
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [55:0]               m_tdata,    // pixel_out, out_col, out_row
	output logic                      m_tlast,    // frame_done
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [nnd_pkg::IDX_W-1:0] cfg_index,
	input  logic [nnd_pkg::REG_W-1:0] cfg_data
);

	nnd_pkg::geom_t   geom;
	nnd_pkg::result_t pos_res;
	nnd_pkg::result_t out_res;
	logic             restart;
	logic             busy;
	logic             room;
	logic             take;
	logic             kept;

	assign s_tready = room && !busy;
	assign take     = s_tvalid && s_tready;

	nnd_cfg #(.MAX_DIM(MAX_DIM)) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.geom      (geom),
		.restart   (restart),
		.busy      (busy)
	);

	nnd_pos #(.MAX_DIM(MAX_DIM)) u_pos (
		.clk      (clk),
		.arst_n   (arst_n),
		.restart  (restart),
		.geom     (geom),
		.take     (take),
		.pixel_in (s_tdata),
		.kept     (kept),
		.res      (pos_res)
	);

	nnd_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && kept),
		.push_res  (pos_res),
		.room      (room),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_res   (out_res)
	);

	// pack output item
	assign m_tdata = {out_res.row, out_res.col, out_res.pixel};
	assign m_tlast = out_res.done;

endmodule
